// ===== rtl/sfd_pkg.sv =====
package sfd_pkg;

    // Field widths of the byte and result words
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int LEN_W  = 7;

    // Default frame store depth and command queue depth
    localparam int BUF_DEPTH_DEF = 64;
    localparam int CQ_DEPTH      = 4;

    // Reset value of the frame size limit register
    localparam logic [LEN_W-1:0] LIMIT_RESET = 7'd64;

    // SLIP special characters
    localparam logic [BYTE_W-1:0] CODE_END     = 8'hC0;
    localparam logic [BYTE_W-1:0] CODE_ESC     = 8'hDB;
    localparam logic [BYTE_W-1:0] CODE_ESC_END = 8'hDC;
    localparam logic [BYTE_W-1:0] CODE_ESC_ESC = 8'hDD;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic ERR_OVERFLOW   = 1'b0;
    localparam logic ERR_BAD_ESCAPE = 1'b1;

    // Commands from the classifier to the replay engine
    typedef enum logic [1:0] {
        OP_STORE,
        OP_REPLAY,
        OP_EMPTY,
        OP_ERROR
    } t_op;

    // len carries the store address for OP_STORE and the frame length for OP_REPLAY
    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              err;
    } t_cmd;

endpackage

// ===== rtl/sfd_front.sv =====
module sfd_front
    import sfd_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_wdata,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd
);

    localparam int CNT_W = $clog2(BUF_DEPTH + 1);

    logic [LEN_W-1:0]  r_limit;
    logic              r_esc;
    logic              n_esc;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  lim_eff;
    logic              store_req;
    logic [BYTE_W-1:0] dec_byte;
    logic              cmd_valid;
    t_cmd              cmd;

    // Saturate the limit at the store depth
    always_comb begin
        if (r_limit > LEN_W'(BUF_DEPTH)) begin
            lim_eff = CNT_W'(BUF_DEPTH);
        end else begin
            lim_eff = r_limit[CNT_W-1:0];
        end
    end

    // Classify the incoming word and build the command for the back end
    always_comb begin
        n_esc     = r_esc;
        n_count   = r_count;
        store_req = 1'b0;
        dec_byte  = i_rx_byte;
        cmd_valid = 1'b0;
        cmd.op    = OP_STORE;
        cmd.data  = i_rx_byte;
        cmd.len   = '0;
        cmd.err   = ERR_OVERFLOW;

        if (r_esc) begin
            priority if (i_rx_byte == CODE_ESC_END) begin
                store_req = 1'b1;
                dec_byte  = CODE_END;
            end else if (i_rx_byte == CODE_ESC_ESC) begin
                store_req = 1'b1;
                dec_byte  = CODE_ESC;
            end else begin
                // Drop the frame on a bad escape sequence
                cmd_valid = 1'b1;
                cmd.op    = OP_ERROR;
                cmd.err   = ERR_BAD_ESCAPE;
                n_esc     = 1'b0;
                n_count   = '0;
            end
        end else begin
            priority if (i_rx_byte == CODE_END) begin
                cmd_valid = 1'b1;
                cmd.op    = (r_count == '0) ? OP_EMPTY : OP_REPLAY;
                cmd.len   = LEN_W'(r_count);
                n_count   = '0;
            end else if (i_rx_byte == CODE_ESC) begin
                n_esc = 1'b1;
            end else begin
                store_req = 1'b1;
            end
        end

        // Store a decoded byte or drop the frame on overflow
        if (store_req) begin
            cmd_valid = 1'b1;
            n_esc     = 1'b0;
            if (r_count >= lim_eff) begin
                cmd.op  = OP_ERROR;
                cmd.err = ERR_OVERFLOW;
                n_count = '0;
            end else begin
                cmd.op   = OP_STORE;
                cmd.data = dec_byte;
                cmd.len  = LEN_W'(r_count);
                n_count  = r_count + CNT_W'(1);
            end
        end
    end

    // Write the limit on a configuration write and advance the frame state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_esc   <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_esc   <= n_esc;
                r_count <= n_count;
            end
        end
    end

    assign o_cmd_valid = i_accept && cmd_valid;
    assign o_cmd       = cmd;

endmodule

// ===== rtl/sfd_cmdq.sv =====
module sfd_cmdq
    import sfd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_data
);

    localparam int PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(CQ_DEPTH + 1);

    t_cmd             r_entries [CQ_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(CQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_entries[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Hold the queued commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entries[r_wr_ptr] <= i_data;
        end
    end

    // Advance the pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(CQ_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(CQ_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/sfd_back.sv =====
module sfd_back
    import sfd_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [KIND_W-1:0] o_result_kind,
    output logic [BYTE_W-1:0] o_byte_value,
    output logic [LEN_W-1:0]  o_frame_length,
    output logic              o_error_code,
    output logic              o_last_of_run
);

    localparam int CNT_W  = $clog2(BUF_DEPTH + 1);
    localparam int ADDR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    logic [BYTE_W-1:0] r_mem [BUF_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    logic              r_busy;
    logic              n_busy;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  n_idx;
    logic [CNT_W-1:0]  r_len;
    logic [CNT_W-1:0]  n_len;

    logic              r_out_valid;
    logic [KIND_W-1:0] r_kind;
    logic [KIND_W-1:0] n_kind;
    logic [LEN_W-1:0]  r_out_len;
    logic [LEN_W-1:0]  n_out_len;
    logic              r_err;
    logic              n_err;
    logic              r_last;
    logic              n_last;

    logic              advance;
    logic              out_load;
    logic              mem_we;
    logic              rd_en;
    logic              cmd_pop;

    // The output register frees up when empty or when its word is taken
    assign advance = !r_out_valid || i_pop;

    // Execute one command or one replay step per cycle when not stalled
    always_comb begin
        n_busy    = r_busy;
        n_idx     = r_idx;
        n_len     = r_len;
        n_kind    = KIND_DATA;
        n_out_len = '0;
        n_err     = ERR_OVERFLOW;
        n_last    = 1'b0;
        out_load  = 1'b0;
        mem_we    = 1'b0;
        rd_en     = 1'b0;
        cmd_pop   = 1'b0;

        if (r_busy) begin
            if (advance) begin
                rd_en     = 1'b1;
                out_load  = 1'b1;
                n_kind    = KIND_DATA;
                n_out_len = LEN_W'(r_len);
                n_last    = (r_idx + CNT_W'(1) == r_len);
                if (n_last) begin
                    n_busy = 1'b0;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
        end else if (i_cmd_valid) begin
            unique case (i_cmd.op)
                OP_STORE: begin
                    cmd_pop = 1'b1;
                    mem_we  = 1'b1;
                end
                OP_REPLAY: begin
                    cmd_pop = 1'b1;
                    n_busy  = 1'b1;
                    n_idx   = '0;
                    n_len   = i_cmd.len[CNT_W-1:0];
                end
                OP_EMPTY: begin
                    if (advance) begin
                        cmd_pop  = 1'b1;
                        out_load = 1'b1;
                        n_kind   = KIND_EMPTY;
                        n_last   = 1'b1;
                    end
                end
                OP_ERROR: begin
                    if (advance) begin
                        cmd_pop  = 1'b1;
                        out_load = 1'b1;
                        n_kind   = KIND_ERROR;
                        n_err    = i_cmd.err;
                        n_last   = 1'b1;
                    end
                end
                default: begin
                    cmd_pop = 1'b0;
                end
            endcase
        end
    end

    // Frame store: write on store commands, registered read on replay steps
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_cmd.len[ADDR_W-1:0]] <= i_cmd.data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx[ADDR_W-1:0]];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (advance) begin
                r_out_valid <= out_load;
            end
        end
    end

    // Replay counters and result fields
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_len <= n_len;
        if (out_load) begin
            r_kind    <= n_kind;
            r_out_len <= n_out_len;
            r_err     <= n_err;
            r_last    <= n_last;
        end
    end

    assign o_cmd_pop      = cmd_pop;
    assign o_empty        = !r_out_valid;
    assign o_result_kind  = r_kind;
    assign o_byte_value   = (r_kind == KIND_DATA) ? r_rd_data : '0;
    assign o_frame_length = r_out_len;
    assign o_error_code   = r_err;
    assign o_last_of_run  = r_last;

endmodule

// ===== rtl/slip_frame_decoder.sv =====
// SLIP receive decoder.
// Input channel: one raw link byte per word on i_rx_byte, taken when push is
// high and full is low. Result channel: the oldest result sits on the o_ ports
// while empty is low and is taken when pop is high.
// Configuration: i_cfg_we/i_cfg_wdata write the frame size limit (reset 64).
// A classifier takes one byte per cycle while the command queue has room,
// tracks the escape state and the frame byte count, and sends store, replay,
// empty and error commands through a four-entry command queue to the replay
// engine, which owns the frame store. Plain data bytes are handled one per
// cycle in both halves unless stalled. An END byte makes the replay engine
// take a setup step, then replay the stored bytes, one memory read each;
// meanwhile the classifier takes next-frame bytes until the queue fills.
// An END byte's first result passes the command queue, the setup step and
// the output register; empty-frame and error results skip the setup step.
// Reset clears the escape state, byte count, command queue, busy and output
// valid flags and sets the limit to 64; the frame store needs no clearing.
// When the receiver stalls, the output register holds its word, the replay
// engine pauses and the input side stalls once the command queue is full.
module slip_frame_decoder
    import sfd_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_wdata,
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              empty,
    input  logic              pop,
    output logic [KIND_W-1:0] o_result_kind,
    output logic [BYTE_W-1:0] o_byte_value,
    output logic [LEN_W-1:0]  o_frame_length,
    output logic              o_error_code,
    output logic              o_last_of_run
);

    logic accept;
    logic cmd_push;
    t_cmd cmd_in;
    logic q_empty;
    t_cmd q_data;
    logic q_pop;

    assign accept = push && !full;

    // Classify incoming bytes
    sfd_front #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .o_cmd_valid (cmd_push),
        .o_cmd       (cmd_in)
    );

    // Decouple the two halves
    sfd_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    // Store and replay frames
    sfd_back #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (!q_empty),
        .i_cmd          (q_data),
        .o_cmd_pop      (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_result_kind  (o_result_kind),
        .o_byte_value   (o_byte_value),
        .o_frame_length (o_frame_length),
        .o_error_code   (o_error_code),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

// ===== rtl/sfd_checker.sv =====
module sfd_props
    import sfd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              empty,
    input logic              pop,
    input logic [KIND_W-1:0] o_result_kind,
    input logic [BYTE_W-1:0] o_byte_value,
    input logic [LEN_W-1:0]  o_frame_length,
    input logic              o_last_of_run
);

    // Data words always belong to a frame of nonzero length
    a_data_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result_kind == KIND_DATA) |-> (o_frame_length != '0))
        else $error("data result with zero frame length");

    // Empty-frame and error results stand alone and carry no length
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result_kind == KIND_EMPTY || o_result_kind == KIND_ERROR))
        |-> (o_last_of_run && o_frame_length == '0 && o_byte_value == '0))
        else $error("empty or error result not a lone zero-length result");

    // Within a replayed frame the length stays the same word to word
    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_result_kind == KIND_DATA && !o_last_of_run)
        ##1 !empty |-> (o_result_kind == KIND_DATA && $stable(o_frame_length)))
        else $error("frame replay broken or length changed mid-run");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result_kind) && $stable(o_byte_value)))
        else $error("stalled result changed");

endmodule

bind slip_frame_decoder sfd_props u_sfd_props (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_result_kind  (o_result_kind),
    .o_byte_value   (o_byte_value),
    .o_frame_length (o_frame_length),
    .o_last_of_run  (o_last_of_run)
);
